// ===== rtl/sam_pkg.sv =====
// shared constants, types and codes of the sensor average monitor
package sam_pkg;

  // sample and window geometry
  localparam int SAMPLE_W      = 12;
  localparam int WINDOW_TAPS   = 8;
  localparam int WIN_W         = $clog2(WINDOW_TAPS);
  localparam int SUM_W         = SAMPLE_W + WIN_W;

  // audio block and band geometry
  localparam int BLOCK_SAMPLES = 64;
  localparam int BAND_COUNT    = 8;
  localparam int BLOCK_W       = $clog2(BLOCK_SAMPLES);
  localparam int PER_BAND      = BLOCK_SAMPLES / BAND_COUNT;
  localparam int PER_W         = $clog2(PER_BAND);
  localparam int BAND_W        = $clog2(BAND_COUNT);
  localparam int BAND_ACC_W    = SAMPLE_W + PER_W;
  localparam int LEVEL_W       = 8;
  localparam int LEVEL_SHIFT   = 4;
  localparam int SHOWN_BANDS   = (BAND_COUNT < 8) ? BAND_COUNT : 8;
  localparam int LEVELS_W      = 64;

  // battery scaling to millivolts
  localparam int MV_SCALE      = 15000;
  localparam int MV_SHIFT      = 12;
  localparam int MV_W          = 14;
  localparam int PRODUCT_W     = SAMPLE_W + MV_W;

  // configuration port
  localparam int CFG_W         = 12;
  localparam int CFG_INDEX_W   = 2;

  // stream widths
  localparam int IN_TDATA_W    = 40;
  localparam int OUT_FIELDS_W  = 4 * SAMPLE_W + MV_W + 4 + LEVELS_W;
  localparam int OUT_TDATA_W   = 136;
  localparam int OUT_PAD_W     = OUT_TDATA_W - OUT_FIELDS_W;

  // register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DAY_THRESHOLD   = 2'd0,
    REG_NIGHT_THRESHOLD = 2'd1,
    REG_BATTERY_LOW     = 2'd2,
    REG_AUDIO_LEVEL     = 2'd3
  } cfg_index_t;

  // sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_CALC
  } state_t;

  // band stage status toward the merge stage
  typedef struct packed {
    logic                updated;
    logic [LEVELS_W-1:0] levels;
  } band_status_t;

endpackage

// ===== rtl/sam_lane.sv =====
// one channel lane: sample window with running sum and average
module sam_lane (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         load,
  input  logic [sam_pkg::WIN_W-1:0]    position,
  input  logic [sam_pkg::SAMPLE_W-1:0] sample,
  output logic [sam_pkg::SAMPLE_W-1:0] average
);
  import sam_pkg::*;

  logic [SAMPLE_W-1:0] window [WINDOW_TAPS];
  logic [SUM_W-1:0]    sum;
  logic [SUM_W-1:0]    sum_next;

  // replace the oldest sample in the running sum
  assign sum_next = sum - SUM_W'(window[position]) + SUM_W'(sample);

  // window and sum update on each transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
      for (int i = 0; i < WINDOW_TAPS; i++) begin
        window[i] <= '0;
      end
    end else if (load) begin
      window[position] <= sample;
      sum              <= sum_next;
    end
  end

  // divide by the tap count
  assign average = sum[SUM_W-1:WIN_W];

endmodule

// ===== rtl/sam_band.sv =====
// audio band stage: per-band accumulation and block-end refresh of band levels
module sam_band (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         load,
  input  logic [sam_pkg::SAMPLE_W-1:0] sample,
  output sam_pkg::band_status_t        status
);
  import sam_pkg::*;

  logic [BLOCK_W-1:0]    block_pos;
  logic [BAND_ACC_W-1:0] band_acc;
  logic [LEVEL_W-1:0]    pending [BAND_COUNT];
  logic [LEVEL_W-1:0]    store [BAND_COUNT];
  logic                  updated;

  logic [PER_W-1:0]      offset;
  logic [BAND_W-1:0]     band_idx;
  logic [BAND_ACC_W-1:0] acc_sum;
  logic [LEVEL_W-1:0]    level;
  logic                  band_done;
  logic                  block_done;

  // position of this sample inside its band and block
  assign offset     = block_pos[PER_W-1:0];
  assign band_idx   = block_pos[BLOCK_W-1:PER_W];
  assign acc_sum    = ((offset == '0) ? '0 : band_acc) + BAND_ACC_W'(sample);
  assign band_done  = (offset == PER_W'(PER_BAND - 1));
  assign block_done = (block_pos == BLOCK_W'(BLOCK_SAMPLES - 1));
  assign level      = LEVEL_W'(acc_sum >> (PER_W + LEVEL_SHIFT));

  // accumulator and finished band levels
  always_ff @(posedge clk) begin
    if (load) begin
      band_acc <= acc_sum;
      if (band_done) begin
        pending[band_idx] <= level;
      end
    end
  end

  // block position and shown band levels
  always_ff @(posedge clk) begin
    if (rst) begin
      block_pos <= '0;
      updated   <= 1'b0;
      for (int b = 0; b < BAND_COUNT; b++) begin
        store[b] <= '0;
      end
    end else if (load) begin
      if (block_done) begin
        block_pos <= '0;
        updated   <= 1'b1;
        for (int b = 0; b < BAND_COUNT; b++) begin
          store[b] <= (band_done && (band_idx == BAND_W'(b))) ? level : pending[b];
        end
      end else begin
        block_pos <= block_pos + 1'b1;
        updated   <= 1'b0;
      end
    end
  end

  // pack shown bands, band 0 in the low byte
  always_comb begin
    status.updated = updated;
    status.levels  = '0;
    for (int b = 0; b < SHOWN_BANDS; b++) begin
      status.levels[b*LEVEL_W +: LEVEL_W] = store[b];
    end
  end

endmodule

// ===== rtl/sensor_average_hysteresis_monitor.sv =====
// top level: channel lanes, band stage and merge stage of the sensor monitor
//
// Each input transaction carries one light, battery and audio sample. The
// block takes no item in its merge cycle: in the accept cycle the three channel
// lanes update their 8-sample windows and running sums and the band stage
// adds the audio sample to its band accumulator; in the next cycle the merge
// stage derives the averages, the day/night hysteresis, the low battery flag,
// the millivolt scaling multiply and the audio peak, and loads the output
// register. That register holds a finished result while the next item is
// accepted; an item waits in the merge cycle only while the previous result
// is still untaken. Windows and band levels come out of reset cleared in
// flip-flops, so there is no clearing pass. Configuration writes take effect
// at once and are meant to be made while the block is idle.
module sensor_average_hysteresis_monitor (
  input  logic                            clk,
  input  logic                            rst,
  // configuration write port
  input  logic                            cfg_we,
  input  logic [sam_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sam_pkg::CFG_W-1:0]       cfg_data,
  // input stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // fields from bit 0: light_sample[11:0], battery_sample[23:12],
  // audio_sample[35:24], zero pad[39:36]
  input  logic [sam_pkg::IN_TDATA_W-1:0]  s_tdata,
  // output stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // fields from bit 0: light_average[11:0], battery_average[23:12],
  // battery_millivolts[37:24], audio_average[49:38], audio_peak[61:50],
  // audio_present[62], night_mode[63], battery_low[64], bands_updated[65],
  // band_levels[129:66], zero pad[135:130]
  output logic [sam_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import sam_pkg::*;

  localparam int PEAK_LSB = 3 * SAMPLE_W + MV_W;

  state_t state;
  state_t state_next;

  logic [CFG_W-1:0]    day_threshold;
  logic [CFG_W-1:0]    night_threshold;
  logic [CFG_W-1:0]    battery_low_level;
  logic [CFG_W-1:0]    audio_level;

  logic [WIN_W-1:0]    window_position;
  logic [SAMPLE_W-1:0] audio_hold;
  logic [SAMPLE_W-1:0] peak_hold;
  logic                night_flag;

  logic                s_accept;
  logic                out_load;

  logic [SAMPLE_W-1:0] light_avg;
  logic [SAMPLE_W-1:0] batt_avg;
  logic [SAMPLE_W-1:0] audio_avg;
  band_status_t        band_status;

  logic                night_next;
  logic [SAMPLE_W-1:0] peak_next;
  logic [PRODUCT_W-1:0] mv_product;
  logic [MV_W-1:0]     millivolts;
  logic                present;
  logic                batt_low;

  assign s_accept = s_tvalid && s_tready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      day_threshold     <= CFG_W'(3000);
      night_threshold   <= CFG_W'(1000);
      battery_low_level <= CFG_W'(3140);
      audio_level       <= CFG_W'(2048);
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        REG_DAY_THRESHOLD:   day_threshold     <= cfg_data;
        REG_NIGHT_THRESHOLD: night_threshold   <= cfg_data;
        REG_BATTERY_LOW:     battery_low_level <= cfg_data;
        REG_AUDIO_LEVEL:     audio_level       <= cfg_data;
      endcase
    end
  end

  // channel lanes
  sam_lane u_light_lane (
    .clk      (clk),
    .rst      (rst),
    .load     (s_accept),
    .position (window_position),
    .sample   (s_tdata[SAMPLE_W-1:0]),
    .average  (light_avg)
  );

  sam_lane u_battery_lane (
    .clk      (clk),
    .rst      (rst),
    .load     (s_accept),
    .position (window_position),
    .sample   (s_tdata[2*SAMPLE_W-1:SAMPLE_W]),
    .average  (batt_avg)
  );

  sam_lane u_audio_lane (
    .clk      (clk),
    .rst      (rst),
    .load     (s_accept),
    .position (window_position),
    .sample   (s_tdata[3*SAMPLE_W-1:2*SAMPLE_W]),
    .average  (audio_avg)
  );

  // audio band stage
  sam_band u_band (
    .clk    (clk),
    .rst    (rst),
    .load   (s_accept),
    .sample (s_tdata[3*SAMPLE_W-1:2*SAMPLE_W]),
    .status (band_status)
  );

  // shared window position and raw audio hold
  always_ff @(posedge clk) begin
    if (rst) begin
      window_position <= '0;
    end else if (s_accept) begin
      window_position <= window_position + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      audio_hold <= s_tdata[3*SAMPLE_W-1:2*SAMPLE_W];
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_accept) state_next = ST_CALC;
      end
      ST_CALC: begin
        if (out_load) state_next = ST_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_tready = 1'b0;
    out_load = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
      end
      ST_CALC: begin
        out_load = !m_tvalid || m_tready;
      end
    endcase
  end

  // merge stage: hysteresis, flags, peak and millivolt scaling
  always_comb begin
    priority if (light_avg > day_threshold) begin
      night_next = 1'b0;
    end else if (light_avg < night_threshold) begin
      night_next = 1'b1;
    end else begin
      // dead band keeps the mode
      night_next = night_flag;
    end
    peak_next  = (audio_hold > peak_hold) ? audio_hold : peak_hold;
    mv_product = PRODUCT_W'(batt_avg) * PRODUCT_W'(MV_SCALE);
    millivolts = mv_product[MV_SHIFT +: MV_W];
    present    = audio_hold > audio_level;
    batt_low   = batt_avg < battery_low_level;
  end

  // monitor state kept across items
  always_ff @(posedge clk) begin
    if (rst) begin
      night_flag <= 1'b0;
      peak_hold  <= '0;
    end else if (out_load) begin
      night_flag <= night_next;
      peak_hold  <= peak_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {{OUT_PAD_W{1'b0}}, band_status.levels, band_status.updated, batt_low,
                  night_next, present, peak_next, audio_avg, millivolts, batt_avg,
                  light_avg};
    end
  end

`ifndef SYNTH
  // an accepted transaction always goes on to the merge cycle
  a_accept_to_calc: assert property (@(posedge clk) disable iff (rst)
    s_accept |=> (state == ST_CALC))
    else $error("accepted transaction did not enter merge cycle");

  // the shared window position advances once per accepted transaction
  a_position_step: assert property (@(posedge clk) disable iff (rst)
    s_accept |=> (window_position == WIN_W'($past(window_position) + 1'b1)))
    else $error("window position did not advance on transaction");

  // a shown peak never exceeds the held peak
  a_peak_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[PEAK_LSB +: SAMPLE_W] <= peak_hold))
    else $error("shown audio peak above held peak");
`endif

endmodule

// ===== dv/testbench.sv =====
// testbench for the sensor average monitor: directed table, random ticks, result scoreboard
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sam_pkg::*;

  localparam int HOLD_CYCLES   = 300;
  localparam int STALL_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_TICKS   = 180;
  localparam int RANDOM_PHASES = 9;
  localparam int MAX_REPORTS   = 40;
  localparam logic [11:0] FULL_SCALE = 12'hFFF;

  // fields of one result transaction, light_average in the lowest bits
  typedef struct packed {
    logic [LEVELS_W-1:0] band_levels;
    logic                bands_updated;
    logic                battery_low;
    logic                night_mode;
    logic                audio_present;
    logic [11:0]         audio_peak;
    logic [11:0]         audio_average;
    logic [MV_W-1:0]     battery_millivolts;
    logic [11:0]         battery_average;
    logic [11:0]         light_average;
  } monitor_result_t;

  // one row of the directed table, with an optional hand-written result
  typedef struct {
    logic [11:0]     light;
    logic [11:0]     batt;
    logic [11:0]     audio;
    bit              typed;
    monitor_result_t want;
  } tick_row_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  cfg_index_t             cfg_index;
  logic [CFG_W-1:0]       cfg_data;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;

  // traffic shaping shared between sender and receiver
  int tx_idle_pct;
  int rx_idle_pct;
  logic hold_ask;

  // scoreboard
  monitor_result_t expected_results[$];
  monitor_result_t got_result;
  monitor_result_t want_result;
  int error_count = 0;
  int results_seen = 0;
  int quiet_cycles = 0;

  // predictor state and register copies
  logic [11:0]          window_copy [3][WINDOW_TAPS];
  logic [WIN_W-1:0]     tap_pos;
  logic [11:0]          block_copy [BLOCK_SAMPLES];
  logic [BLOCK_W-1:0]   block_pos;
  logic [11:0]          peak_copy;
  logic                 night_copy;
  logic [LEVEL_W-1:0]   level_copy [BAND_COUNT];
  logic [11:0]          day_thr;
  logic [11:0]          night_thr;
  logic [11:0]          batt_low_thr;
  logic [11:0]          audio_thr;

  tick_row_t directed_rows[$];

  sensor_average_hysteresis_monitor dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // predictor reset, matching the block's reset values
  function automatic void clear_monitor_copy();
    for (int ch = 0; ch < 3; ch++)
      for (int i = 0; i < WINDOW_TAPS; i++) window_copy[ch][i] = '0;
    for (int i = 0; i < BLOCK_SAMPLES; i++) block_copy[i] = '0;
    for (int b = 0; b < BAND_COUNT; b++) level_copy[b] = '0;
    tap_pos    = '0;
    block_pos  = '0;
    peak_copy  = '0;
    night_copy = 1'b0;
    day_thr      = 12'd3000;
    night_thr    = 12'd1000;
    batt_low_thr = 12'd3140;
    audio_thr    = 12'd2048;
  endfunction

  // advance the predictor by one sensor tick and return the result it gives
  function automatic monitor_result_t predict_tick(logic [11:0] light, logic [11:0] batt,
                                                   logic [11:0] audio);
    monitor_result_t r;
    int unsigned sums [3];
    int unsigned group_total;
    int unsigned light_avg;
    int unsigned batt_avg;
    int unsigned audio_avg;
    int unsigned mv;
    r = '0;
    window_copy[0][tap_pos] = light;
    window_copy[1][tap_pos] = batt;
    window_copy[2][tap_pos] = audio;
    for (int ch = 0; ch < 3; ch++) begin
      sums[ch] = 0;
      for (int i = 0; i < WINDOW_TAPS; i++) sums[ch] += window_copy[ch][i];
    end
    light_avg = sums[0] / WINDOW_TAPS;
    batt_avg  = sums[1] / WINDOW_TAPS;
    audio_avg = sums[2] / WINDOW_TAPS;
    // band refresh when this sample closes the block
    block_copy[block_pos] = audio;
    if (block_pos == BLOCK_W'(BLOCK_SAMPLES - 1)) begin
      for (int b = 0; b < BAND_COUNT; b++) begin
        group_total = 0;
        for (int j = 0; j < PER_BAND; j++) group_total += block_copy[b * PER_BAND + j];
        level_copy[b] = LEVEL_W'((group_total / PER_BAND) >> LEVEL_SHIFT);
      end
      r.bands_updated = 1'b1;
    end
    block_pos = block_pos + 1'b1;
    if (audio > peak_copy) peak_copy = audio;
    tap_pos = tap_pos + 1'b1;
    // hysteresis, day test first
    if (light_avg > day_thr) night_copy = 1'b0;
    else if (light_avg < night_thr) night_copy = 1'b1;
    mv = (batt_avg * MV_SCALE) >> MV_SHIFT;
    r.light_average      = 12'(light_avg);
    r.battery_average    = 12'(batt_avg);
    r.battery_millivolts = MV_W'(mv);
    r.audio_average      = 12'(audio_avg);
    r.audio_peak         = peak_copy;
    r.audio_present      = audio > audio_thr;
    r.night_mode         = night_copy;
    r.battery_low        = batt_avg < batt_low_thr;
    for (int b = 0; b < SHOWN_BANDS; b++) r.band_levels[8*b +: 8] = level_copy[b];
    return r;
  endfunction

  function automatic monitor_result_t typed_result(int la, int ba, int mv, int aa, int pk,
                                                   bit pr, bit nm, bit lo);
    monitor_result_t r;
    r = '0;
    r.light_average      = 12'(la);
    r.battery_average    = 12'(ba);
    r.battery_millivolts = MV_W'(mv);
    r.audio_average      = 12'(aa);
    r.audio_peak         = 12'(pk);
    r.audio_present      = pr;
    r.night_mode         = nm;
    r.battery_low        = lo;
    return r;
  endfunction

  function automatic void add_row(logic [11:0] light, logic [11:0] batt, logic [11:0] audio);
    tick_row_t row;
    row.light = light;
    row.batt  = batt;
    row.audio = audio;
    row.typed = 1'b0;
    row.want  = '0;
    directed_rows.push_back(row);
  endfunction

  // random value biased toward the extremes and toward a threshold
  function automatic logic [11:0] pick_sample(logic [11:0] thr);
    int v;
    case ($urandom_range(7))
      0: v = 0;
      1: v = 4095;
      2, 3: begin
        v = int'(thr) + int'($urandom_range(16)) - 8;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
      end
      default: v = int'($urandom_range(4095));
    endcase
    return 12'(v);
  endfunction

  task automatic report_mismatch(string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("ERROR result %0d: %s", results_seen, msg);
  endtask

  task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want) report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
  endtask

  // all four registers, written back to back while idle
  task automatic write_thresholds(logic [11:0] d, logic [11:0] n, logic [11:0] b,
                                  logic [11:0] a);
    cfg_we    <= 1'b1;
    cfg_index <= REG_DAY_THRESHOLD;
    cfg_data  <= d;
    @(posedge clk);
    cfg_index <= REG_NIGHT_THRESHOLD;
    cfg_data  <= n;
    @(posedge clk);
    cfg_index <= REG_BATTERY_LOW;
    cfg_data  <= b;
    @(posedge clk);
    cfg_index <= REG_AUDIO_LEVEL;
    cfg_data  <= a;
    @(posedge clk);
    cfg_we <= 1'b0;
    day_thr      = d;
    night_thr    = n;
    batt_low_thr = b;
    audio_thr    = a;
  endtask

  // one input transaction, with random idle cycles ahead of it
  task automatic send_tick(logic [11:0] light, logic [11:0] batt, logic [11:0] audio);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, audio, batt, light};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // receiver: random ready, plus one long hold-off on request
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_ask && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // scoreboard: compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result transaction with nothing expected");
      end else begin
        want_result = expected_results.pop_front();
        got_result  = monitor_result_t'(m_tdata[OUT_FIELDS_W-1:0]);
        check_field("light_average", 64'(got_result.light_average),
                    64'(want_result.light_average));
        check_field("battery_average", 64'(got_result.battery_average),
                    64'(want_result.battery_average));
        check_field("battery_millivolts", 64'(got_result.battery_millivolts),
                    64'(want_result.battery_millivolts));
        check_field("audio_average", 64'(got_result.audio_average),
                    64'(want_result.audio_average));
        check_field("audio_peak", 64'(got_result.audio_peak), 64'(want_result.audio_peak));
        check_field("audio_present", 64'(got_result.audio_present),
                    64'(want_result.audio_present));
        check_field("night_mode", 64'(got_result.night_mode), 64'(want_result.night_mode));
        check_field("battery_low", 64'(got_result.battery_low),
                    64'(want_result.battery_low));
        check_field("bands_updated", 64'(got_result.bands_updated),
                    64'(want_result.bands_updated));
        check_field("band_levels", got_result.band_levels, want_result.band_levels);
        check_field("pad bits", 64'(m_tdata[OUT_TDATA_W-1:OUT_FIELDS_W]), 64'd0);
      end
      results_seen++;
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles < STALL_LIMIT) begin
      quiet_cycles <= quiet_cycles + 1;
    end else begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // main sequence
  initial begin
    logic [11:0] light_base;
    logic [11:0] light;
    logic [11:0] d;
    logic [11:0] n;
    logic [11:0] b;
    logic [11:0] a;
    monitor_result_t predicted;
    rst         <= 1'b1;
    cfg_we      <= 1'b0;
    cfg_index   <= REG_DAY_THRESHOLD;
    cfg_data    <= '0;
    s_tvalid    <= 1'b0;
    s_tdata     <= '0;
    hold_ask    = 1'b0;
    tx_idle_pct = 16;
    rx_idle_pct = 84;
    clear_monitor_copy();

    // directed rows: reset state, full scale, thresholds, dead band, night entry
    add_row(12'd0, 12'd0, 12'd0);
    for (int i = 0; i < 8; i++) add_row(FULL_SCALE, FULL_SCALE, FULL_SCALE);
    add_row(FULL_SCALE, FULL_SCALE, 12'd2048);
    add_row(FULL_SCALE, FULL_SCALE, 12'd2049);
    for (int i = 0; i < 8; i++) add_row(12'd2000, 12'd3140, 12'(i * 300));
    for (int i = 0; i < 5; i++) add_row(12'd0, 12'd3139, (i % 2) ? FULL_SCALE : 12'd0);
    directed_rows[0].typed = 1'b1;
    directed_rows[0].want  = typed_result(0, 0, 0, 0, 0, 1'b0, 1'b1, 1'b1);
    directed_rows[1].typed = 1'b1;
    directed_rows[1].want  = typed_result(511, 511, 1871, 511, 4095, 1'b1, 1'b1, 1'b1);
    directed_rows[8].typed = 1'b1;
    directed_rows[8].want  = typed_result(4095, 4095, 14996, 4095, 4095, 1'b1, 1'b0, 1'b0);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    write_thresholds(12'd3000, 12'd1000, 12'd3140, 12'd2048);
    foreach (directed_rows[i]) begin
      send_tick(directed_rows[i].light, directed_rows[i].batt, directed_rows[i].audio);
      predicted = predict_tick(directed_rows[i].light, directed_rows[i].batt,
                               directed_rows[i].audio);
      expected_results.push_back(directed_rows[i].typed ? directed_rows[i].want : predicted);
    end
    wait_for_results();

    // random phases, each under its own register setting
    light_base = 12'd2000;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: write_thresholds(12'd0, 12'd0, 12'd0, 12'd0);
        1: write_thresholds(FULL_SCALE, FULL_SCALE, FULL_SCALE, FULL_SCALE);
        // overlapping thresholds: day test wins
        2: write_thresholds(12'd500, 12'd3500, 12'd2000, 12'd100);
        default: begin
          d = 12'($urandom_range(4095, 1200));
          n = 12'($urandom_range(int'(d), 0));
          b = 12'($urandom_range(4095));
          a = 12'($urandom_range(4095));
          write_thresholds(d, n, b, a);
        end
      endcase
      case (phase / 3)
        0: begin
          tx_idle_pct = 16;
          rx_idle_pct = 84;
        end
        1: begin
          tx_idle_pct = 84;
          rx_idle_pct = 16;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      for (int i = 0; i < PHASE_TICKS; i++) begin
        if (phase == 4 && i == 40) hold_ask = 1'b1;
        if (phase == 7 && i == 90) wait_for_results();
        // light level held for a while so the average settles across thresholds
        if ($urandom_range(11) == 0)
          light_base = pick_sample($urandom_range(1) ? day_thr : night_thr);
        light = ($urandom_range(3) == 0) ? pick_sample(night_thr) : light_base;
        d = pick_sample(batt_low_thr);
        a = pick_sample(audio_thr);
        send_tick(light, d, a);
        expected_results.push_back(predict_tick(light, d, a));
      end
      wait_for_results();
    end

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
